/* hw/rtl/radix_string_to_integer_core_assert.svh */
// assertion macros for the radix string converter
// clocked on clk, held off while rst_n is low
`ifndef RADIX_STRING_TO_INTEGER_CORE_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSI_ASSERT_SAME(lbl, ante, cons, msg)
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/rsi_pkg.sv */
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int OUT_WIDTH   = 64;

  typedef enum logic [1:0] {
    MODE_HEX = 2'd0,
    MODE_DEC = 2'd1,
    MODE_OCT = 2'd2,
    MODE_BIN = 2'd3
  } mode_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef logic [VALUE_WIDTH-1:0] value_t;

endpackage

/* hw/rtl/radix_string_to_integer_core.sv */
`timescale 1ns / 1ps
// channel  dir  tdata                tuser        tlast
// in_      in   [7:0] char_code      [1:0] mode   last
// out_     out  [63:0] value         [0] error    -
//
// one character a cycle: input register, then one shift-add stage into the
// accumulator; the times-ten add (two shifts plus digit) sets the path
// a result word enters the output register once its last character leaves the input register
// rst_n synchronous, clears valids and the mid-string flag
// input stalls only when a last character waits on a full, stalled output word
`include "radix_string_to_integer_core_assert.svh"

module radix_string_to_integer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [0:0]  out_tuser   // [0] error
);

  // input register
  logic                 s1_vld_r, s1_vld_nxt;
  logic [7:0]           s1_char_r;
  logic [1:0]           s1_mode_r;
  logic                 s1_last_r;

  // conversion state
  rsi_pkg::value_t      acc_r, acc_nxt;
  logic                 err_r, err_nxt;
  logic                 stop_r, stop_nxt;
  logic                 mid_r, mid_nxt;
  rsi_pkg::mode_t       mode_r, mode_nxt;

  // output register
  logic                 out_vld_r, out_vld_nxt;
  rsi_pkg::value_t      out_val_r;
  logic                 out_err_r;

  logic                 s1_adv;
  logic                 in_acc;
  logic                 first;
  rsi_pkg::mode_t       mode_eff;
  rsi_pkg::value_t      acc_base, prod, acc_step;
  logic                 err_base, stop_base;
  logic                 is_dec, is_hexl, is_oct, is_bin, dig_ok;
  logic [3:0]           digit;

  assign s1_adv    = s1_vld_r && !(s1_last_r && out_vld_r && !out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_tdata;
      s1_mode_r <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  // character decode
  always_comb begin
    is_dec  = (s1_char_r >= rsi_pkg::CH_ZERO) && (s1_char_r <= rsi_pkg::CH_NINE);
    is_hexl = (s1_char_r >= rsi_pkg::CH_A) && (s1_char_r <= rsi_pkg::CH_F);
    is_oct  = (s1_char_r >= rsi_pkg::CH_ZERO) && (s1_char_r <= rsi_pkg::CH_SEVEN);
    is_bin  = (s1_char_r == rsi_pkg::CH_ZERO) || (s1_char_r == rsi_pkg::CH_ONE);
    // 'A' has low nibble 1, so letter value is nibble plus 9
    digit   = is_dec ? s1_char_r[3:0] : 4'(s1_char_r[3:0] + 4'd9);
  end

  always_comb begin
    first     = !mid_r;
    mode_eff  = first ? rsi_pkg::mode_t'(s1_mode_r) : mode_r;
    acc_base  = first ? '0 : acc_r;
    err_base  = first ? 1'b0 : err_r;
    stop_base = first ? 1'b0 : stop_r;

    case (mode_eff)
      rsi_pkg::MODE_HEX: begin
        prod   = acc_base << 4;
        dig_ok = is_dec || is_hexl;
      end
      rsi_pkg::MODE_DEC: begin
        prod   = (acc_base << 3) + (acc_base << 1);
        dig_ok = is_dec;
      end
      rsi_pkg::MODE_OCT: begin
        prod   = acc_base << 3;
        dig_ok = is_oct;
      end
      rsi_pkg::MODE_BIN: begin
        prod   = acc_base << 1;
        dig_ok = is_bin;
      end
      default: begin
        prod   = acc_base << 1;
        dig_ok = is_bin;
      end
    endcase

    acc_step = prod + rsi_pkg::value_t'(digit);

    acc_nxt  = acc_r;
    err_nxt  = err_r;
    stop_nxt = stop_r;
    mid_nxt  = mid_r;
    mode_nxt = mode_r;
    if (s1_adv) begin
      mode_nxt = mode_eff;
      acc_nxt  = acc_base;
      err_nxt  = err_base;
      stop_nxt = stop_base;
      if (!err_base && !stop_base) begin
        if (dig_ok) begin
          acc_nxt = acc_step;
        end else if (mode_eff == rsi_pkg::MODE_DEC) begin
          stop_nxt = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
      mid_nxt = !s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= 1'b0;
      err_r  <= 1'b0;
      stop_r <= 1'b0;
      mode_r <= rsi_pkg::MODE_HEX;
      acc_r  <= '0;
    end else begin
      mid_r  <= mid_nxt;
      err_r  <= err_nxt;
      stop_r <= stop_nxt;
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // result word
  assign out_vld_nxt = (out_vld_r && !out_tready) || (s1_adv && s1_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_val_r <= err_nxt ? '1 : acc_nxt;
      out_err_r <= err_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = rsi_pkg::OUT_WIDTH'(out_val_r);
  assign out_tuser[0] = out_err_r;

  `RSI_ASSERT_SAME(a_err_all_ones, out_vld_r && out_err_r, out_val_r == '1, "error word not all ones")
  `RSI_ASSERT_NEXT(a_last_gives_word, s1_adv && s1_last_r, out_vld_r, "last character gave no word")
  `RSI_ASSERT_NEXT(a_last_ends_string, s1_adv && s1_last_r, !mid_r, "string still open after last")
  `RSI_ASSERT_SAME(a_stall_needs_item, !in_tready, s1_vld_r && s1_last_r && out_vld_r, "bad input stall")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  // predicts the converted value of each string and checks the results in order
  class radix_checker;
    logic [63:0]    acc;
    bit             err;
    bit             stopped;
    bit             busy;
    rsi_pkg::mode_t cur_mode;
    logic [63:0]    exp_values[$];
    bit             exp_errors[$];
    int             fails;

    function new();
      acc = '0;
      err = 0;
      stopped = 0;
      busy = 0;
      cur_mode = rsi_pkg::MODE_HEX;
      fails = 0;
    endfunction

    function int pending();
      return exp_values.size();
    endfunction

    function void note_char(logic [7:0] c, logic [1:0] m, logic last);
      logic [63:0] digit;
      logic [63:0] base;
      bit          ok;
      // mode is taken from the first character only
      if (!busy) begin
        cur_mode = rsi_pkg::mode_t'(m);
        acc = '0;
        err = 0;
        stopped = 0;
        busy = 1;
      end
      ok = 0;
      digit = '0;
      case (cur_mode)
        rsi_pkg::MODE_HEX: begin
          base = 16;
          if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_NINE) begin
            digit = c - rsi_pkg::CH_ZERO;
            ok = 1;
          end else if (c >= rsi_pkg::CH_A && c <= rsi_pkg::CH_F) begin
            digit = c - rsi_pkg::CH_A + 10;
            ok = 1;
          end
        end
        rsi_pkg::MODE_DEC: begin
          base = 10;
          if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_NINE) begin
            digit = c - rsi_pkg::CH_ZERO;
            ok = 1;
          end
        end
        rsi_pkg::MODE_OCT: begin
          base = 8;
          if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_SEVEN) begin
            digit = c - rsi_pkg::CH_ZERO;
            ok = 1;
          end
        end
        default: begin
          base = 2;
          if (c == rsi_pkg::CH_ZERO || c == rsi_pkg::CH_ONE) begin
            digit = c - rsi_pkg::CH_ZERO;
            ok = 1;
          end
        end
      endcase
      if (!err && !stopped) begin
        if (ok) begin
          acc = acc * base + digit;
        end else if (cur_mode == rsi_pkg::MODE_DEC) begin
          stopped = 1;
        end else begin
          err = 1;
        end
      end
      if (last) begin
        exp_values.push_back(err ? {64{1'b1}} : acc);
        exp_errors.push_back(err);
        busy = 0;
      end
    endfunction

    function void check_result(logic [63:0] v, logic e);
      logic [63:0] want_v;
      bit          want_e;
      if (exp_values.size() == 0) begin
        $error("unexpected result word: value %h error %0b", v, e);
        fails++;
        return;
      end
      want_v = exp_values.pop_front();
      want_e = exp_errors.pop_front();
      if (v !== want_v) begin
        $error("value: expected %h, got %h", want_v, v);
        fails++;
      end
      if (e !== want_e) begin
        $error("error: expected %0b, got %0b", want_e, e);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  radix_checker sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int chars_sent = 0;

  radix_string_to_integer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    end
  end

  // receiver: random stalls, plus long hold-offs requested by the sender side
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic [1:0] m, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= m;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  // later characters carry a random mode, which the block must ignore
  task automatic send_str(input string s, input rsi_pkg::mode_t m);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], (i == 0) ? m : 2'($urandom_range(3)), i == s.len() - 1);
    end
  endtask

  task automatic send_random_string();
    int             len;
    int             r;
    int             d;
    rsi_pkg::mode_t m;
    logic [7:0]     c;
    m = rsi_pkg::mode_t'($urandom_range(3));
    r = $urandom_range(99);
    len = (r < 80) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 24)
                                                     : $urandom_range(25, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6) begin
        c = 8'($urandom_range(255));
      end else begin
        case (m)
          rsi_pkg::MODE_HEX: begin
            d = $urandom_range(15);
            c = (d < 10) ? rsi_pkg::CH_ZERO + 8'(d) : rsi_pkg::CH_A + 8'(d - 10);
          end
          rsi_pkg::MODE_DEC: c = rsi_pkg::CH_ZERO + 8'($urandom_range(9));
          rsi_pkg::MODE_OCT: c = rsi_pkg::CH_ZERO + 8'($urandom_range(7));
          default:           c = rsi_pkg::CH_ZERO + 8'($urandom_range(1));
        endcase
      end
      send_char(c, (i == 0) ? m : 2'($urandom_range(3)), i == len - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 31;
    rx_idle_pct = 50;
    send_str("9AF", rsi_pkg::MODE_HEX);
    send_str("a1", rsi_pkg::MODE_HEX);   // lowercase is invalid, later digit ignored
    send_str("-5", rsi_pkg::MODE_DEC);   // sign is not skipped
    send_str("12x3", rsi_pkg::MODE_DEC); // stops at the first non-digit
    send_str("78", rsi_pkg::MODE_OCT);
    send_str("101", rsi_pkg::MODE_BIN);
    send_str("2", rsi_pkg::MODE_BIN);
    send_char(8'h00, rsi_pkg::MODE_HEX, 1'b0);
    send_char(8'hFF, rsi_pkg::MODE_DEC, 1'b1);

    while (chars_sent < 270) send_random_string();
    // long output stall so the block backs up into its input
    hold_left = 300;
    while (chars_sent < 400) send_random_string();
    drain();

    tx_idle_pct = 50;
    rx_idle_pct = 31;
    while (chars_sent < 600) send_random_string();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (chars_sent < 830) send_random_string();

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
